// ===== sv/ptom_pkg.sv =====
// types, codes and constants shared by the order matcher modules
package ptom_pkg;

   localparam int ORDER_CAPACITY_DEF = 32;

   typedef enum logic [1:0] {
      MODE_LIMIT  = 2'd0,
      MODE_MARKET = 2'd1,
      MODE_CANCEL = 2'd2,
      MODE_UNUSED = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_RESTED    = 3'd0,
      ST_FILLED    = 3'd1,
      ST_DROPPED   = 3'd2,
      ST_CANCELLED = 3'd3,
      ST_NOT_FOUND = 3'd4,
      ST_BOOK_FULL = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      SCAN_MATCH,
      SCAN_CANCEL,
      SCAN_BOOK
   } scan_kind_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_MATCH_SCAN,
      S_MATCH_DECIDE,
      S_FILL,
      S_REST,
      S_CANCEL_SCAN,
      S_CANCEL_APPLY,
      S_BOOK_SCAN,
      S_SUMMARY
   } state_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic        side;
      logic [31:0] limit_price;
      logic [31:0] quantity;
      logic [31:0] order_id;
      logic [63:0] timestamp;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] maker_id;
      logic [31:0] taker_id;
      logic [31:0] trade_price;
      logic [31:0] fill_quantity;
      logic [63:0] trade_time;
      logic [2:0]  status;
      logic [31:0] top_bid;
      logic        top_bid_valid;
      logic [31:0] top_ask;
      logic        top_ask_valid;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic          load_req;
      logic          scan_start;
      scan_kind_type scan_kind;
      logic          emit_fill;
      logic          apply_rest;
      logic          apply_cancel;
      logic          emit_summary;
      logic          set_status;
      status_type    status_val;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     qty_zero;
      logic     fill_ends;
      logic     scan_done;
      logic     found;
      logic     rsp_free;
   } sts_type;

endpackage

// ===== sv/ptom_ctrl.sv =====
// sequencer for match, rest, cancel and summary steps
module ptom_ctrl
   import ptom_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_accept,
   input  sts_type sts,
   output logic    idle,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.scan_kind  = SCAN_BOOK;
      cmd.status_val = ST_NOT_FOUND;
      idle     = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               cmd.load_req = 1'b1;
               state_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (sts.mode) inside
               MODE_LIMIT, MODE_MARKET: begin
                  if (sts.qty_zero) begin
                     cmd.set_status = 1'b1;
                     cmd.status_val = ST_FILLED;
                     cmd.scan_start = 1'b1;
                     cmd.scan_kind  = SCAN_BOOK;
                     state_in       = S_BOOK_SCAN;
                  end else begin
                     cmd.scan_start = 1'b1;
                     cmd.scan_kind  = SCAN_MATCH;
                     state_in       = S_MATCH_SCAN;
                  end
               end
               MODE_CANCEL: begin
                  cmd.scan_start = 1'b1;
                  cmd.scan_kind  = SCAN_CANCEL;
                  state_in       = S_CANCEL_SCAN;
               end
               default: begin
                  cmd.set_status = 1'b1;
                  cmd.status_val = ST_NOT_FOUND;
                  cmd.scan_start = 1'b1;
                  cmd.scan_kind  = SCAN_BOOK;
                  state_in       = S_BOOK_SCAN;
               end
            endcase
         end
         S_MATCH_SCAN: begin
            if (sts.scan_done) begin
               state_in = S_MATCH_DECIDE;
            end
         end
         S_MATCH_DECIDE: begin
            if (sts.found) begin
               state_in = S_FILL;
            end else if (sts.mode == MODE_MARKET) begin
               cmd.set_status = 1'b1;
               cmd.status_val = ST_DROPPED;
               cmd.scan_start = 1'b1;
               cmd.scan_kind  = SCAN_BOOK;
               state_in       = S_BOOK_SCAN;
            end else begin
               state_in = S_REST;
            end
         end
         S_FILL: begin
            if (sts.rsp_free) begin
               cmd.emit_fill  = 1'b1;
               cmd.scan_start = 1'b1;
               if (sts.fill_ends) begin
                  cmd.set_status = 1'b1;
                  cmd.status_val = ST_FILLED;
                  cmd.scan_kind  = SCAN_BOOK;
                  state_in       = S_BOOK_SCAN;
               end else begin
                  cmd.scan_kind = SCAN_MATCH;
                  state_in      = S_MATCH_SCAN;
               end
            end
         end
         S_REST: begin
            cmd.apply_rest = 1'b1;
            cmd.scan_start = 1'b1;
            cmd.scan_kind  = SCAN_BOOK;
            state_in       = S_BOOK_SCAN;
         end
         S_CANCEL_SCAN: begin
            if (sts.scan_done) begin
               state_in = S_CANCEL_APPLY;
            end
         end
         S_CANCEL_APPLY: begin
            cmd.apply_cancel = 1'b1;
            cmd.scan_start   = 1'b1;
            cmd.scan_kind    = SCAN_BOOK;
            state_in         = S_BOOK_SCAN;
         end
         S_BOOK_SCAN: begin
            if (sts.scan_done) begin
               state_in = S_SUMMARY;
            end
         end
         S_SUMMARY: begin
            if (sts.rsp_free) begin
               cmd.emit_summary = 1'b1;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      req_accept |-> state_ff == S_IDLE)
      else $error("transfer accepted while busy");

   assert property (@(posedge clock) disable iff (reset)
      cmd.emit_fill |-> $past(state_ff) == S_MATCH_DECIDE || $past(state_ff) == S_FILL)
      else $error("fill without match decision");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FILL |-> $past(sts.found))
      else $error("fill state without maker");

endmodule

// ===== sv/ptom_dp.sv =====
// order book storage, scan unit and result register
module ptom_dp
   import ptom_pkg::*;
#(
   parameter int ORDER_CAPACITY = ORDER_CAPACITY_DEF
)
(
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  cmd_type cmd,
   output sts_type sts,
   input  logic    rsp_stall,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int IDX_W = $clog2(ORDER_CAPACITY);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ORDER_CAPACITY - 1);

   typedef struct packed {
      logic        side;
      logic [31:0] price;
      logic [31:0] ident;
      logic [31:0] arrival;
   } meta_type;

   meta_type    meta_mem [ORDER_CAPACITY];
   logic [31:0] rem_mem  [ORDER_CAPACITY];
   logic        valid_ff [ORDER_CAPACITY];

   req_type       req_ff;
   logic [31:0]   leaves_ff;
   status_type    status_ff;
   logic [31:0]   arrival_ff;

   logic          run_ff;
   logic [IDX_W-1:0] addr_ff;
   scan_kind_type kind_ff;
   logic          rd_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   meta_type      rd_meta_ff;
   logic [31:0]   rd_rem_ff;
   logic          rd_vbit_ff;

   logic          found_ff;
   logic [IDX_W-1:0] best_idx_ff;
   logic [31:0]   best_price_ff;
   logic [31:0]   best_age_ff;
   logic [31:0]   best_rem_ff;
   logic [31:0]   best_ident_ff;
   logic          free_found_ff;
   logic [IDX_W-1:0] free_idx_ff;
   logic [31:0]   bid_ff, ask_ff;
   logic          bid_valid_ff, ask_valid_ff;

   logic          rsp_valid_ff;
   rsp_type       rsp_ff;
   rsp_type       rsp_in;

   logic          rsp_free;
   logic [31:0]   fill_qty;
   logic [31:0]   age;
   logic          in_limit;
   logic          candidate;
   logic          better;

   logic          wr_en;
   logic [IDX_W-1:0] wr_idx;
   logic [31:0]   wr_rem;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign fill_qty  = (leaves_ff < best_rem_ff) ? leaves_ff : best_rem_ff;
   assign age       = arrival_ff - rd_meta_ff.arrival;
   assign in_limit  = (req_ff.mode != MODE_LIMIT) ||
                      (req_ff.side ? (rd_meta_ff.price >= req_ff.limit_price)
                                   : (rd_meta_ff.price <= req_ff.limit_price));
   assign candidate = rd_vbit_ff && (rd_meta_ff.side != req_ff.side) && in_limit;

   always_comb begin
      if (!found_ff) begin
         better = 1'b1;
      end else if (rd_meta_ff.price == best_price_ff) begin
         better = age > best_age_ff;
      end else if (!req_ff.side) begin
         better = rd_meta_ff.price < best_price_ff;
      end else begin
         better = rd_meta_ff.price > best_price_ff;
      end
   end

   assign sts.mode      = mode_type'(req_ff.mode);
   assign sts.qty_zero  = (req_ff.quantity == '0);
   assign sts.fill_ends = (leaves_ff <= best_rem_ff);
   assign sts.scan_done = rd_ff && (rd_idx_ff == LAST_IDX);
   assign sts.found     = found_ff;
   assign sts.rsp_free  = rsp_free;

   // remaining quantity write port
   always_comb begin
      wr_en  = 1'b0;
      wr_idx = best_idx_ff;
      wr_rem = best_rem_ff - fill_qty;
      if (cmd.emit_fill) begin
         wr_en = 1'b1;
      end else if (cmd.apply_rest && free_found_ff) begin
         wr_en  = 1'b1;
         wr_idx = free_idx_ff;
         wr_rem = leaves_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rem_mem[wr_idx] <= wr_rem;
      end
      if (cmd.apply_rest && free_found_ff) begin
         meta_mem[free_idx_ff] <= '{side: req_ff.side, price: req_ff.limit_price,
                                    ident: req_ff.order_id, arrival: arrival_ff};
      end
      rd_meta_ff <= meta_mem[addr_ff];
      rd_rem_ff  <= rem_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ORDER_CAPACITY; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         if (cmd.emit_fill && (best_rem_ff == fill_qty)) begin
            valid_ff[best_idx_ff] <= 1'b0;
         end
         if (cmd.apply_rest && free_found_ff) begin
            valid_ff[free_idx_ff] <= 1'b1;
         end
         if (cmd.apply_cancel && found_ff) begin
            valid_ff[best_idx_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         arrival_ff <= '0;
         run_ff     <= 1'b0;
         rd_ff      <= 1'b0;
      end else begin
         if (cmd.apply_rest && free_found_ff) begin
            arrival_ff <= arrival_ff + 32'd1;
         end
         rd_ff <= run_ff;
         if (cmd.scan_start) begin
            run_ff <= 1'b1;
         end else if (run_ff && (addr_ff == LAST_IDX)) begin
            run_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff  <= addr_ff;
      rd_vbit_ff <= valid_ff[addr_ff];
      if (cmd.scan_start) begin
         addr_ff <= '0;
         kind_ff <= cmd.scan_kind;
      end else if (run_ff && (addr_ff != LAST_IDX)) begin
         addr_ff <= addr_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff    <= req_data;
         leaves_ff <= req_data.quantity;
      end
      if (cmd.emit_fill) begin
         leaves_ff <= leaves_ff - fill_qty;
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status_val;
      end else if (cmd.apply_rest) begin
         status_ff <= free_found_ff ? ST_RESTED : ST_BOOK_FULL;
      end else if (cmd.apply_cancel) begin
         status_ff <= found_ff ? ST_CANCELLED : ST_NOT_FOUND;
      end
   end

   // scan accumulators
   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         bid_valid_ff  <= 1'b0;
         ask_valid_ff  <= 1'b0;
      end else if (rd_ff) begin
         case (kind_ff)
            SCAN_MATCH: begin
               if (candidate && better) begin
                  found_ff      <= 1'b1;
                  best_idx_ff   <= rd_idx_ff;
                  best_price_ff <= rd_meta_ff.price;
                  best_age_ff   <= age;
                  best_rem_ff   <= rd_rem_ff;
                  best_ident_ff <= rd_meta_ff.ident;
               end
               if (!rd_vbit_ff && !free_found_ff) begin
                  free_found_ff <= 1'b1;
                  free_idx_ff   <= rd_idx_ff;
               end
            end
            SCAN_CANCEL: begin
               if (rd_vbit_ff && !found_ff && (rd_meta_ff.ident == req_ff.order_id)) begin
                  found_ff    <= 1'b1;
                  best_idx_ff <= rd_idx_ff;
               end
            end
            default: begin
               if (rd_vbit_ff && !rd_meta_ff.side) begin
                  if (!bid_valid_ff || (rd_meta_ff.price > bid_ff)) begin
                     bid_ff <= rd_meta_ff.price;
                  end
                  bid_valid_ff <= 1'b1;
               end
               if (rd_vbit_ff && rd_meta_ff.side) begin
                  if (!ask_valid_ff || (rd_meta_ff.price < ask_ff)) begin
                     ask_ff <= rd_meta_ff.price;
                  end
                  ask_valid_ff <= 1'b1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_fill || cmd.emit_summary) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      rsp_in = '0;
      if (cmd.emit_fill) begin
         rsp_in.maker_id      = best_ident_ff;
         rsp_in.taker_id      = req_ff.order_id;
         rsp_in.trade_price   = best_price_ff;
         rsp_in.fill_quantity = fill_qty;
         rsp_in.trade_time    = req_ff.timestamp;
      end else begin
         rsp_in.kind          = 1'b1;
         rsp_in.status        = status_ff;
         rsp_in.top_bid       = bid_valid_ff ? bid_ff : '0;
         rsp_in.top_bid_valid = bid_valid_ff;
         rsp_in.top_ask       = ask_valid_ff ? ask_ff : '0;
         rsp_in.top_ask_valid = ask_valid_ff;
         rsp_in.last          = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_fill || cmd.emit_summary) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_fill || cmd.emit_summary) |-> rsp_free)
      else $error("result register overwritten");

   assert property (@(posedge clock) disable iff (reset)
      cmd.emit_fill |-> found_ff && (fill_qty != '0))
      else $error("fill without maker quantity");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.apply_rest && free_found_ff) |=> valid_ff[$past(free_idx_ff)])
      else $error("rested order not marked valid");

   assert property (@(posedge clock) disable iff (reset)
      sts.scan_done |-> !run_ff)
      else $error("scan finished while still issuing");

endmodule

// ===== sv/price_time_order_matcher_top.sv =====
// price-time priority order book matcher, top level
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid, req_stall | req_data (req_type)
//  rsp     | out       | rsp_valid, rsp_stall | rsp_data (rsp_type)
//
// one item at a time; each book scan reads one slot per cycle
// synchronous reset clears all valid bits at once; no clearing pass; input stalled in reset
// a stalled result holds the sequencer until its register is free
module price_time_order_matcher_top
   import ptom_pkg::*;
#(
   parameter int ORDER_CAPACITY = ORDER_CAPACITY_DEF
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;
   logic    idle;
   logic    req_accept;

   assign req_stall  = reset || !idle;
   assign req_accept = req_valid && !req_stall;

   ptom_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .sts        (sts),
      .idle       (idle),
      .cmd        (cmd)
   );

   ptom_dp #(
      .ORDER_CAPACITY (ORDER_CAPACITY)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
